// ===== sv/i2r_pkg.sv =====
`timescale 1ns / 1ps
package i2r_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_BASE_DEF    = 16;

  localparam int IN_W       = 32;
  localparam int CHAR_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int SIZE_W     = 5;
  localparam int ALPHA_N    = 16;
  localparam int ALPHA_W    = ALPHA_N * CHAR_W;

  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_LOW  = 2'd0,
    CFG_ALPHA_HIGH = 2'd1,
    CFG_BASE_SIZE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic chk_next;
    logic div_step;
    logic out_load;
    logic out_sign;
    logic ptr_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic size_ok;
    logic char_bad;
    logic chk_last;
    logic div_last;
    logic digits_done;
    logic neg;
    logic out_free;
    logic ptr_zero;
  } dp_stat_t;

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alph,
                                                   input logic [3:0] idx);
    return alph[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

// ===== sv/i2r_in_if.sv =====
`timescale 1ns / 1ps
interface i2r_in_if;
  import i2r_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/i2r_out_if.sv =====
`timescale 1ns / 1ps
interface i2r_out_if;
  import i2r_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_char;

  modport source (output valid, output char_out, output last_char, input ready);
  modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

// ===== sv/i2r_ram.sv =====
`timescale 1ns / 1ps
module i2r_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/i2r_dp.sv =====
`timescale 1ns / 1ps
module i2r_dp #(
  parameter int MAX_BASE    = i2r_pkg::MAX_BASE_DEF,
  parameter int VALUE_WIDTH = i2r_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i2r_pkg::dp_cmd_t              cmd,
  output i2r_pkg::dp_stat_t             st,
  input  logic [VALUE_WIDTH-1:0]        value,
  input  logic [i2r_pkg::ALPHA_W-1:0]   alph,
  input  logic [i2r_pkg::SIZE_W-1:0]    size,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [i2r_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);
  import i2r_pkg::*;

  localparam int DIG_W  = $clog2(MAX_BASE);
  localparam int AW     = $clog2(VALUE_WIDTH);
  localparam int BCNT_W = $clog2(VALUE_WIDTH);
  localparam logic [SIZE_W-1:0] MaxBaseS = SIZE_W'(MAX_BASE);

  logic                   neg_r;
  logic [VALUE_WIDTH-1:0] quo_r;
  logic [DIG_W-1:0]       rem_r;
  logic [BCNT_W-1:0]      bcnt_r;
  logic [AW-1:0]          wr_idx_r;
  logic [AW-1:0]          ptr_r;
  logic [3:0]             chk_idx_r;

  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;

  logic [CHAR_W-1:0]      cur_char;
  logic                   dup;
  logic [DIG_W:0]         trial;
  logic [DIG_W:0]         size_t;
  logic [DIG_W:0]         diff;
  logic                   ge;
  logic [DIG_W-1:0]       rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_nxt;
  logic                   div_last;
  logic                   ram_we;
  logic [DIG_W-1:0]       rdata;
  logic [CHAR_W-1:0]      out_char_nxt;

  // alphabet check, one character per cycle against all later ones
  assign cur_char = alpha_char(alph, chk_idx_r);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < ALPHA_N; j++) begin
      if (4'(j) > chk_idx_r && SIZE_W'(j) < size && alpha_char(alph, 4'(j)) == cur_char) begin
        dup = 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  assign trial   = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign size_t  = size[DIG_W:0];
  assign ge      = trial >= size_t;
  assign diff    = trial - size_t;
  assign rem_nxt = ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
  assign quo_nxt = {quo_r[VALUE_WIDTH-2:0], ge};

  assign div_last = bcnt_r == BCNT_W'(VALUE_WIDTH - 1);
  assign ram_we   = cmd.div_step && div_last;

  always_comb begin
    st.size_ok     = size >= SIZE_W'(2) && size <= MaxBaseS;
    st.char_bad    = cur_char < CHAR_LOW || cur_char > CHAR_HIGH ||
                     cur_char == CHAR_MINUS || cur_char == CHAR_PLUS || dup;
    st.chk_last    = {1'b0, chk_idx_r} == size - SIZE_W'(1);
    st.div_last    = div_last;
    st.digits_done = quo_nxt == '0 || wr_idx_r == AW'(VALUE_WIDTH - 1);
    st.neg         = neg_r;
    st.out_free    = !out_valid_r || out_ready;
    st.ptr_zero    = ptr_r == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r     <= value[VALUE_WIDTH-1];
      quo_r     <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      rem_r     <= '0;
      bcnt_r    <= '0;
      wr_idx_r  <= '0;
      chk_idx_r <= '0;
    end else begin
      if (cmd.chk_next) begin
        chk_idx_r <= chk_idx_r + 4'd1;
      end
      if (cmd.div_step) begin
        quo_r <= quo_nxt;
        if (div_last) begin
          rem_r    <= '0;
          bcnt_r   <= '0;
          ptr_r    <= wr_idx_r;
          wr_idx_r <= wr_idx_r + AW'(1);
        end else begin
          rem_r  <= rem_nxt;
          bcnt_r <= bcnt_r + BCNT_W'(1);
        end
      end
      if (cmd.ptr_dec) begin
        ptr_r <= ptr_r - AW'(1);
      end
    end
  end

  i2r_ram #(
    .WIDTH(DIG_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata(rem_nxt),
    .raddr(ptr_r),
    .rdata(rdata)
  );

  assign out_char_nxt = cmd.out_sign ? CHAR_MINUS : alpha_char(alph, 4'(rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= !cmd.out_sign && ptr_r == '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_digit_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> SIZE_W'(rem_nxt) < size)
    else $error("digit not below radix");

  a_last_not_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_char_r != CHAR_MINUS)
    else $error("sign flagged as last character");

endmodule

// ===== sv/i2r_ctrl.sv =====
`timescale 1ns / 1ps
module i2r_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2r_pkg::dp_stat_t  st,
  output i2r_pkg::dp_cmd_t   cmd
);
  import i2r_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!st.size_ok || st.char_bad) begin
          state_nxt = ST_IDLE;
        end else if (st.chk_last) begin
          state_nxt = ST_DIVIDE;
        end else begin
          cmd.chk_next = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (st.div_last && st.digits_done) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!st.neg) begin
          state_nxt = ST_FETCH;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sign = 1'b1;
          state_nxt    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.ptr_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_nxt   = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_divide_needs_valid_radix: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == ST_CHECK && state_r == ST_DIVIDE |-> $past(st.size_ok))
    else $error("division started with invalid radix");

  a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && cmd.out_sign |-> st.neg)
    else $error("sign sent for non-negative value");

endmodule

// ===== sv/integer_to_radix_digits.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Transfer
// in_chan   in   value[31:0] (signed)             valid && ready
// out_chan  out  char_out[7:0], last_char         valid && ready
// cfg_*     in   cfg_index[1:0], cfg_data[63:0]   cfg_we
//
// One number at a time: an accept step, a check of each alphabet character up
// to base_size, a pass of the shared bit-serial divider per digit, a sign step,
// then a fetch and an emit per digit character through the registered digit RAM read.
// Invalid alphabet or radix: ends at the first failing character, no output.
// Synchronous active-low reset; output stalls hold the sequencer in place.
module integer_to_radix_digits #(
  parameter int MAX_BASE    = i2r_pkg::MAX_BASE_DEF,
  parameter int VALUE_WIDTH = i2r_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  i2r_in_if.sink                          in_chan,
  i2r_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [i2r_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2r_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2r_pkg::*;

  logic [CFG_DATA_W-1:0] alph_lo_r;
  logic [CFG_DATA_W-1:0] alph_hi_r;
  logic [SIZE_W-1:0]     base_size_r;

  dp_cmd_t  cmd;
  dp_stat_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alph_lo_r   <= '0;
      alph_hi_r   <= '0;
      base_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_LOW:  alph_lo_r   <= cfg_data;
        CFG_ALPHA_HIGH: alph_hi_r   <= cfg_data;
        CFG_BASE_SIZE:  base_size_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  i2r_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .st      (st),
    .cmd     (cmd)
  );

  i2r_dp #(
    .MAX_BASE   (MAX_BASE),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .value    (in_chan.value[VALUE_WIDTH-1:0]),
    .alph     ({alph_hi_r, alph_lo_r}),
    .size     (base_size_r),
    .out_ready(out_chan.ready),
    .out_valid(out_chan.valid),
    .out_char (out_chan.char_out),
    .out_last (out_chan.last_char)
  );

endmodule
